// File: rtl/assert_macros.svh
// assertion macros for the rtl files of the deque block
// expects clk and arst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("deque assertion failed");

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("deque forbidden condition seen");

`endif

// File: rtl/bdq_pkg.sv
// shared types and codes of the bounded deque with search
// no dependencies
package bdq_pkg;

	localparam int OP_W     = 3;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 4;
	localparam int OCC_W    = 5;

	// operation codes
	localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_REM_FRONT = 3'd2;
	localparam logic [OP_W-1:0] OP_REM_BACK  = 3'd3;
	localparam logic [OP_W-1:0] OP_SEARCH    = 3'd4;
	localparam logic [OP_W-1:0] OP_DUMP      = 3'd5;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_MISS  = 2'd3;

	// what every cell of the chain does at each clock edge
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_SHR,
		CELL_SHL,
		CELL_WR
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t                cmd;
		logic signed [DATA_W-1:0] wdata;
	} cell_ctl_t;

endpackage

// File: rtl/bounded_deque_with_search.sv
// top level of the bounded deque with linear search
// depends on bdq_pkg, bdq_cell and assert_macros.svh
//
// usage:
// - request channel (req_valid, req_stall) carries operation and value; a
//   transaction completes at a clock edge with req_valid high and req_stall low
// - response channel (rsp_valid, rsp_stall) carries status, element, position,
//   element_valid, occupancy and last; last marks the final response of a request
// - the list lives in a chain of DEPTH cells in front-to-back order, cell 0 is
//   the front; inserts at the front shift the chain right, removes at the front
//   shift it left; insert back writes past the tail, remove back reads the tail
// - inserts, removes and undefined codes give a single response: it is
//   registered and shows in the cycle after the request transaction
// - search and dump rotate the occupied cells past cell 0, one element a cycle
//   while the receiver does not stall, n rotations for n elements, which leaves
//   the order as it was; a dump gives one response per element, a search gives
//   a single response after the last rotation; no new request is taken until then
// - when the receiver stalls, the response register holds and the rotation
//   pauses; a new request is taken as soon as the register can be refilled
// - reset empties the list at once; cell contents are never cleared, the
//   element count keeps every read inside written cells
`include "assert_macros.svh"

module bounded_deque_with_search
	import bdq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// request channel
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic [OP_W-1:0]            operation,
	input  logic signed [DATA_W-1:0]   value,
	// response channel
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic [STATUS_W-1:0]        status,
	output logic signed [DATA_W-1:0]   element,
	output logic [POS_W-1:0]           position,
	output logic                       element_valid,
	output logic [OCC_W-1:0]           occupancy,
	output logic                       last
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// control state
	state_t                   state_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         scan_k_q;
	logic                     scan_dump_q;
	logic                     found_q;
	logic signed [DATA_W-1:0] key_q;
	logic signed [DATA_W-1:0] found_elem_q;
	logic [POS_W-1:0]         found_pos_q;

	// response register
	logic                     rsp_valid_q;
	logic [STATUS_W-1:0]      status_q;
	logic signed [DATA_W-1:0] element_q;
	logic [POS_W-1:0]         position_q;
	logic                     element_valid_q;
	logic [OCC_W-1:0]         occupancy_q;
	logic                     last_q;

	// chain wiring
	cell_ctl_t                cell_ctl;
	logic signed [DATA_W-1:0] cell_data  [DEPTH];
	logic signed [DATA_W-1:0] cell_left  [DEPTH];
	logic signed [DATA_W-1:0] cell_right [DEPTH];
	logic [DEPTH-1:0]         is_tail;
	logic [DEPTH-1:0]         is_wr;
	logic signed [DATA_W-1:0] head_data;
	logic signed [DATA_W-1:0] tail_data;

	logic                     out_free;
	logic                     accept;
	logic                     full;
	logic                     empty;
	logic [CNT_W-1:0]         cnt_m1;
	logic                     scan_step;
	logic                     scan_end;
	logic                     key_hit;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE) || !out_free;
	assign accept    = req_valid && !req_stall;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign cnt_m1    = count_q - 1'b1;
	assign head_data = cell_data[0];
	assign scan_step = (state_q == ST_SCAN) && out_free;
	assign scan_end  = (scan_k_q == cnt_m1);
	assign key_hit   = (head_data == key_q);

	// the chain of cells; the tail cell wraps back to the front when rotating
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign is_tail[i] = (count_q == CNT_W'(i + 1));
		assign is_wr[i]   = (count_q == CNT_W'(i));

		if (i == 0) begin : g_first
			assign cell_left[i] = value;
		end else begin : g_inner_l
			assign cell_left[i] = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_end
			assign cell_right[i] = cell_data[0];
		end else begin : g_inner_r
			assign cell_right[i] = is_tail[i] ? cell_data[0] : cell_data[i+1];
		end

		bdq_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl),
			.left_data  (cell_left[i]),
			.right_data (cell_right[i]),
			.wr_slot    (is_wr[i]),
			.data       (cell_data[i])
		);
	end

	// and-or pick of the tail cell for remove back
	always_comb begin
		tail_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tail_data = tail_data | (is_tail[i] ? cell_data[i] : '0);
		end
	end

	// chain command for this cycle
	always_comb begin
		cell_ctl.cmd   = CELL_HOLD;
		cell_ctl.wdata = value;
		if (accept) begin
			case (operation)
				OP_INS_FRONT: begin
					if (!full) cell_ctl.cmd = CELL_SHR;
				end
				OP_INS_BACK: begin
					if (!full) cell_ctl.cmd = CELL_WR;
				end
				OP_REM_FRONT: begin
					if (!empty) cell_ctl.cmd = CELL_SHL;
				end
				default: begin
					cell_ctl.cmd = CELL_HOLD;
				end
			endcase
		end else if (scan_step) begin
			cell_ctl.cmd = CELL_SHL;
		end
	end

	// state machine and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			count_q         <= '0;
			scan_k_q        <= '0;
			scan_dump_q     <= 1'b0;
			found_q         <= 1'b0;
			key_q           <= '0;
			found_elem_q    <= '0;
			found_pos_q     <= '0;
			rsp_valid_q     <= 1'b0;
			status_q        <= STAT_OK;
			element_q       <= '0;
			position_q      <= '0;
			element_valid_q <= 1'b0;
			occupancy_q     <= '0;
			last_q          <= 1'b0;
		end else begin
			// response taken and nothing new behind it
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// single-response defaults
						rsp_valid_q     <= 1'b1;
						status_q        <= STAT_OK;
						element_q       <= '0;
						position_q      <= '0;
						element_valid_q <= 1'b0;
						occupancy_q     <= OCC_W'(count_q);
						last_q          <= 1'b1;
						case (operation)
							OP_INS_FRONT, OP_INS_BACK: begin
								if (full) begin
									status_q <= STAT_FULL;
								end else begin
									count_q     <= count_q + 1'b1;
									occupancy_q <= OCC_W'(count_q + 1'b1);
								end
							end
							OP_REM_FRONT: begin
								if (empty) begin
									status_q <= STAT_EMPTY;
								end else begin
									count_q         <= cnt_m1;
									occupancy_q     <= OCC_W'(cnt_m1);
									element_q       <= head_data;
									element_valid_q <= 1'b1;
								end
							end
							OP_REM_BACK: begin
								if (empty) begin
									status_q <= STAT_EMPTY;
								end else begin
									count_q         <= cnt_m1;
									occupancy_q     <= OCC_W'(cnt_m1);
									element_q       <= tail_data;
									position_q      <= POS_W'(cnt_m1);
									element_valid_q <= 1'b1;
								end
							end
							OP_SEARCH: begin
								if (empty) begin
									status_q <= STAT_MISS;
								end else begin
									rsp_valid_q <= 1'b0;
									state_q     <= ST_SCAN;
									scan_dump_q <= 1'b0;
									scan_k_q    <= '0;
									found_q     <= 1'b0;
									key_q       <= value;
								end
							end
							OP_DUMP: begin
								if (empty) begin
									status_q <= STAT_EMPTY;
								end else begin
									rsp_valid_q <= 1'b0;
									state_q     <= ST_SCAN;
									scan_dump_q <= 1'b1;
									scan_k_q    <= '0;
								end
							end
							default: begin
								status_q <= STAT_OK;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_step) begin
						scan_k_q <= scan_k_q + 1'b1;
						if (scan_end) begin
							state_q <= ST_IDLE;
						end
						if (scan_dump_q) begin
							// one response per element, front to back
							rsp_valid_q     <= 1'b1;
							status_q        <= STAT_OK;
							element_q       <= head_data;
							position_q      <= POS_W'(scan_k_q);
							element_valid_q <= 1'b1;
							occupancy_q     <= OCC_W'(count_q);
							last_q          <= scan_end;
						end else begin
							// remember the first match, answer after the last rotation
							if (!found_q && key_hit) begin
								found_q      <= 1'b1;
								found_elem_q <= head_data;
								found_pos_q  <= POS_W'(scan_k_q);
							end
							if (scan_end) begin
								rsp_valid_q <= 1'b1;
								occupancy_q <= OCC_W'(count_q);
								last_q      <= 1'b1;
								if (found_q) begin
									status_q        <= STAT_OK;
									element_q       <= found_elem_q;
									position_q      <= found_pos_q;
									element_valid_q <= 1'b1;
								end else if (key_hit) begin
									status_q        <= STAT_OK;
									element_q       <= head_data;
									position_q      <= POS_W'(scan_k_q);
									element_valid_q <= 1'b1;
								end else begin
									status_q        <= STAT_MISS;
									element_q       <= '0;
									position_q      <= '0;
									element_valid_q <= 1'b0;
								end
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign element       = element_q;
	assign position      = position_q;
	assign element_valid = element_valid_q;
	assign occupancy     = occupancy_q;
	assign last          = last_q;

	// checks
	`ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(DEPTH))
	`ASSERT_ALWAYS(a_scan_blocks_req, (state_q == ST_SCAN) |-> req_stall)
	`ASSERT_ALWAYS(a_scan_keeps_count, (state_q == ST_SCAN) |=> $stable(count_q))
	`ASSERT_ALWAYS(a_scan_nonempty, (state_q == ST_SCAN) |-> (count_q != '0))
	`ASSERT_NEVER(a_no_entry_zero, rsp_valid && !element_valid && (element != '0))

endmodule

// File: rtl/bdq_cell.sv
// one storage cell of the deque chain
// depends on bdq_pkg
module bdq_cell
	import bdq_pkg::*;
(
	input  logic                     clk,
	input  cell_ctl_t                ctl,
	input  logic signed [DATA_W-1:0] left_data,
	input  logic signed [DATA_W-1:0] right_data,
	input  logic                     wr_slot,
	output logic signed [DATA_W-1:0] data
);

	logic signed [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CELL_SHR: begin
				data_q <= left_data;
			end
			CELL_SHL: begin
				data_q <= right_data;
			end
			CELL_WR: begin
				if (wr_slot) begin
					data_q <= ctl.wdata;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data = data_q;

endmodule
